// ----- design/assert_macros.svh -----
// assertion macros used by the checker file
// depends on nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: label");

// next-cycle implication checked every clock outside reset
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: label");

`endif

// ----- design/fmacl_pkg.sv -----
// package for the first-match packet acl
// types, constants and request codes shared by the controller, datapath and top level
`timescale 1ns / 1ps

package fmacl_pkg;

  localparam int RuleDepth = 1024;
  localparam int IdxW = $clog2(RuleDepth);
  localparam int CntW = $clog2(RuleDepth + 1);
  localparam int OutIdxW = 10;

  typedef enum logic [1:0] {
    REQ_CLASSIFY = 2'd0,
    REQ_ADD      = 2'd1,
    REQ_CLEAR    = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_HIT,
    ST_DONE,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch the incoming item
    logic scan_start; // zero the scan index
    logic rd_issue;   // read rule slot at scan index
    logic scan_next;  // move to next slot
    logic hit_read;   // read hit counter of current slot
    logic hit_write;  // write incremented hit counter
    logic do_add;     // append rule
    logic do_clear;   // clear table and packet counters
    logic do_count;   // finish classify, update counters
    logic out_load;   // load output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    req_t req;
    logic scan;       // classify needs a rule scan
    logic scan_end;   // scan index reached rules in use
    logic slot_match; // registered slot matches the packet
  } stat_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] src_netmask;
    logic [31:0] dst_addr;
    logic [31:0] dst_netmask;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic [7:0]  proto;
    logic        deny;
  } rule_t;

endpackage

// ----- design/fmacl_ctrl.sv -----
// controller state machine for the acl
// depends on fmacl_pkg
`timescale 1ns / 1ps

module fmacl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  fmacl_pkg::stat_t   stat,
  output fmacl_pkg::cmd_t    cmd
);

  fmacl_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmacl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fmacl_pkg::ST_IDLE: begin
        if (in_valid) state_next = fmacl_pkg::ST_READ;
      end
      fmacl_pkg::ST_READ: begin
        if (stat.req == fmacl_pkg::REQ_CLASSIFY && stat.scan && !stat.scan_end) begin
          state_next = fmacl_pkg::ST_CHECK;
        end else begin
          state_next = fmacl_pkg::ST_DONE;
        end
      end
      fmacl_pkg::ST_CHECK: begin
        if (stat.slot_match) state_next = fmacl_pkg::ST_HIT;
        else state_next = fmacl_pkg::ST_READ;
      end
      fmacl_pkg::ST_HIT: state_next = fmacl_pkg::ST_DONE;
      fmacl_pkg::ST_DONE: state_next = fmacl_pkg::ST_OUT;
      fmacl_pkg::ST_OUT: begin
        if (out_ready) state_next = fmacl_pkg::ST_IDLE;
      end
      default: state_next = fmacl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      fmacl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid;
        cmd.scan_start = in_valid;
      end
      fmacl_pkg::ST_READ: begin
        cmd.rd_issue = stat.req == fmacl_pkg::REQ_CLASSIFY && stat.scan && !stat.scan_end;
      end
      fmacl_pkg::ST_CHECK: begin
        cmd.hit_read = stat.slot_match;
        cmd.scan_next = !stat.slot_match;
      end
      fmacl_pkg::ST_HIT: begin
        cmd.hit_write = 1'b1;
      end
      fmacl_pkg::ST_DONE: begin
        cmd.do_add = stat.req == fmacl_pkg::REQ_ADD;
        cmd.do_clear = stat.req == fmacl_pkg::REQ_CLEAR;
        cmd.do_count = stat.req == fmacl_pkg::REQ_CLASSIFY;
        cmd.out_load = 1'b1;
      end
      fmacl_pkg::ST_OUT: begin
        out_valid = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ----- design/fmacl_dp.sv -----
// datapath for the acl: rule memory, hit counters, packet counters
// depends on fmacl_pkg
`timescale 1ns / 1ps

module fmacl_dp (
  input  logic              clk,
  input  logic              rst,
  input  fmacl_pkg::cmd_t   cmd,
  output fmacl_pkg::stat_t  stat,
  input  logic              dflt_action,
  input  logic [1:0]        req_type,
  input  logic              parse_ok,
  input  logic              is_ipv4,
  input  logic [31:0]       src_addr,
  input  logic [31:0]       dst_addr,
  input  logic [31:0]       src_netmask,
  input  logic [31:0]       dst_netmask,
  input  logic [7:0]        protocol,
  input  logic [15:0]       dport_low,
  input  logic [15:0]       dport_high,
  input  logic              rule_action,
  output logic              verdict,
  output logic              matched,
  output logic [9:0]        rule_index,
  output logic [63:0]       rule_hits,
  output logic              add_status,
  output logic [63:0]       total_count,
  output logic [63:0]       allowed_count,
  output logic [63:0]       denied_count
);

  fmacl_pkg::rule_t rule_mem [fmacl_pkg::RuleDepth];
  logic [63:0] hit_mem [fmacl_pkg::RuleDepth];

  // captured item
  fmacl_pkg::req_t          req;
  logic                     pok, v4, act;
  logic [31:0]              sa, da, sm, dm;
  logic [7:0]               pr;
  logic [15:0]              plo, phi;

  logic [fmacl_pkg::CntW-1:0] rules_in_use;
  logic [fmacl_pkg::CntW-1:0] scan_idx;
  logic [63:0]                pkt_total, pkt_allowed, pkt_denied;
  fmacl_pkg::rule_t           rd_rule;
  logic [63:0]                hit_rd;
  logic                       hit_found;
  logic                       hit_deny;
  logic                       slot_match;
  logic                       verdict_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= fmacl_pkg::req_t'(req_type);
      pok <= parse_ok;
      v4  <= is_ipv4;
      sa  <= src_addr;
      da  <= dst_addr;
      sm  <= src_netmask;
      dm  <= dst_netmask;
      pr  <= protocol;
      plo <= dport_low;
      phi <= dport_high;
      act <= rule_action;
    end
  end

  // rule memory: one write port for add, one read port for the scan
  always_ff @(posedge clk) begin
    if (cmd.do_add && rules_in_use < fmacl_pkg::CntW'(fmacl_pkg::RuleDepth)) begin
      rule_mem[rules_in_use[fmacl_pkg::IdxW-1:0]] <= '{sa, sm, da, dm, plo, phi, pr, act};
    end
    if (cmd.rd_issue) begin
      rd_rule <= rule_mem[scan_idx[fmacl_pkg::IdxW-1:0]];
    end
  end

  // hit counter memory: cleared on add, bumped on a hit
  always_ff @(posedge clk) begin
    if (cmd.do_add && rules_in_use < fmacl_pkg::CntW'(fmacl_pkg::RuleDepth)) begin
      hit_mem[rules_in_use[fmacl_pkg::IdxW-1:0]] <= '0;
    end else if (cmd.hit_write) begin
      hit_mem[scan_idx[fmacl_pkg::IdxW-1:0]] <= hit_rd + 64'd1;
    end
    if (cmd.hit_read) begin
      hit_rd <= hit_mem[scan_idx[fmacl_pkg::IdxW-1:0]];
    end
  end

  always_comb begin
    slot_match = 1'b1;
    if (rd_rule.src_addr != '0 &&
        (sa & rd_rule.src_netmask) != (rd_rule.src_addr & rd_rule.src_netmask))
      slot_match = 1'b0;
    if (rd_rule.dst_addr != '0 &&
        (da & rd_rule.dst_netmask) != (rd_rule.dst_addr & rd_rule.dst_netmask))
      slot_match = 1'b0;
    if (rd_rule.proto != '0 && pr != rd_rule.proto)
      slot_match = 1'b0;
    if (plo < rd_rule.port_low || plo > rd_rule.port_high)
      slot_match = 1'b0;
  end

  always_comb begin
    stat.req = req;
    stat.scan = pok && v4;
    stat.scan_end = scan_idx >= rules_in_use;
    stat.slot_match = slot_match;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
      hit_found <= 1'b0;
    end else if (cmd.scan_next) begin
      scan_idx <= scan_idx + fmacl_pkg::CntW'(1);
    end else if (cmd.hit_read) begin
      hit_found <= 1'b1;
      hit_deny <= rd_rule.deny;
    end
  end

  always_comb begin
    if (!pok) verdict_next = 1'b1;
    else if (hit_found) verdict_next = hit_deny;
    else verdict_next = dflt_action;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rules_in_use <= '0;
      pkt_total <= '0;
      pkt_allowed <= '0;
      pkt_denied <= '0;
    end else if (cmd.do_clear) begin
      rules_in_use <= '0;
      pkt_total <= '0;
      pkt_allowed <= '0;
      pkt_denied <= '0;
    end else if (cmd.do_add) begin
      if (rules_in_use < fmacl_pkg::CntW'(fmacl_pkg::RuleDepth))
        rules_in_use <= rules_in_use + fmacl_pkg::CntW'(1);
    end else if (cmd.do_count) begin
      pkt_total <= pkt_total + 64'd1;
      if (verdict_next) pkt_denied <= pkt_denied + 64'd1;
      else pkt_allowed <= pkt_allowed + 64'd1;
    end
  end

  // output register, loaded the cycle the counters update
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      verdict <= (req == fmacl_pkg::REQ_CLASSIFY) ? verdict_next : 1'b0;
      matched <= (req == fmacl_pkg::REQ_CLASSIFY) && hit_found;
      rule_index <= ((req == fmacl_pkg::REQ_CLASSIFY) && hit_found) ?
                    fmacl_pkg::OutIdxW'(scan_idx) : '0;
      rule_hits <= ((req == fmacl_pkg::REQ_CLASSIFY) && hit_found) ? hit_rd + 64'd1 : '0;
      add_status <= (req == fmacl_pkg::REQ_ADD) &&
                    rules_in_use >= fmacl_pkg::CntW'(fmacl_pkg::RuleDepth);
      case (req)
        fmacl_pkg::REQ_CLEAR: begin
          total_count <= '0;
          allowed_count <= '0;
          denied_count <= '0;
        end
        fmacl_pkg::REQ_CLASSIFY: begin
          total_count <= pkt_total + 64'd1;
          allowed_count <= verdict_next ? pkt_allowed : pkt_allowed + 64'd1;
          denied_count <= verdict_next ? pkt_denied + 64'd1 : pkt_denied;
        end
        default: begin
          total_count <= pkt_total;
          allowed_count <= pkt_allowed;
          denied_count <= pkt_denied;
        end
      endcase
    end
  end

endmodule

// ----- design/first_match_packet_acl.sv -----
// top level of the first-match packet acl
// depends on fmacl_pkg, fmacl_ctrl, fmacl_dp
//
// channel  handshake                signals
// in       in_valid / in_ready      req_type .. rule_action
// out      out_valid / out_ready    verdict .. denied_count
// cfg      cfg_valid / cfg_ready    cfg_data (default verdict)
//
// one item at a time; add, clear and unknown items pass from accept through READ and DONE to the result in OUT
// classify scans rule slots in order over the single memory read port,
// reading each slot in READ and checking it in CHECK, until the first match or rules_in_use
// synchronous reset empties the table and zeroes the packet counters, no clearing pass
// out_valid holds until out_ready; no new item is taken meanwhile
`timescale 1ns / 1ps

module first_match_packet_acl (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic        parse_ok,
  input  logic        is_ipv4,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [31:0] src_netmask,
  input  logic [31:0] dst_netmask,
  input  logic [7:0]  protocol,
  input  logic [15:0] dport_low,
  input  logic [15:0] dport_high,
  input  logic        rule_action,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        verdict,
  output logic        matched,
  output logic [9:0]  rule_index,
  output logic [63:0] rule_hits,
  output logic        add_status,
  output logic [63:0] total_count,
  output logic [63:0] allowed_count,
  output logic [63:0] denied_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  fmacl_pkg::cmd_t  cmd;
  fmacl_pkg::stat_t stat;
  logic             dflt_action;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dflt_action <= 1'b0;
    end else if (cfg_valid) begin
      dflt_action <= cfg_data;
    end
  end

  fmacl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  fmacl_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .dflt_action    (dflt_action),
    .req_type       (req_type),
    .parse_ok       (parse_ok),
    .is_ipv4        (is_ipv4),
    .src_addr       (src_addr),
    .dst_addr       (dst_addr),
    .src_netmask    (src_netmask),
    .dst_netmask    (dst_netmask),
    .protocol       (protocol),
    .dport_low      (dport_low),
    .dport_high     (dport_high),
    .rule_action    (rule_action),
    .verdict        (verdict),
    .matched        (matched),
    .rule_index     (rule_index),
    .rule_hits      (rule_hits),
    .add_status     (add_status),
    .total_count    (total_count),
    .allowed_count  (allowed_count),
    .denied_count   (denied_count)
  );

endmodule

// ----- design/fmacl_checker.sv -----
// port-level checks for the acl
// depends on assert_macros.svh; bound to first_match_packet_acl
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fmacl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        matched,
  input logic [9:0]  rule_index,
  input logic [63:0] total_count,
  input logic [63:0] allowed_count,
  input logic [63:0] denied_count
);

  `CHK_IMPL(a_one_at_a_time, clk, rst, out_valid, !in_ready)
  `CHK_NEXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(total_count))
  `CHK_IMPL(a_counts_sum, clk, rst, out_valid, total_count == allowed_count + denied_count)
  `CHK_IMPL(a_index_needs_match, clk, rst, out_valid && !matched, rule_index == 10'd0)

endmodule

bind first_match_packet_acl fmacl_checker u_fmacl_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .matched       (matched),
  .rule_index    (rule_index),
  .total_count   (total_count),
  .allowed_count (allowed_count),
  .denied_count  (denied_count)
);
